// ===== src/niedgen_pkg.sv =====
// Shared types and constants of the Niederreiter sequence generator.
`default_nettype none
package niedgen_pkg;

  localparam int IDX_W   = 63;
  localparam int DIM_W   = 8;
  localparam int NUM_W   = 64;
  localparam int REC_W   = 128;
  localparam int POLY_W  = 16;
  localparam logic [POLY_W-1:0] FIRST_POLY = 16'h0002;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IRR_INIT,
    S_IRR_STEP,
    S_DIM_INIT,
    S_COL,
    S_MUL,
    S_SEED,
    S_REC,
    S_FIN_BUILD,
    S_QUERY,
    S_QDRAIN,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic irr_init;
    logic irr_step;
    logic build_start;
    logic dim_init;
    logic mul_init;
    logic mul_step;
    logic seed;
    logic rec_step;
    logic col_write;
    logic dim_next;
    logic set_ready;
    logic q_start;
    logic q_issue;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic table_ready;
    logic dim_bad;
    logic irr_done;
    logic u_is_e;
    logic mul_last;
    logic rec_done;
    logic col_last;
    logic dim_last;
    logic q_last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== src/niederreiter_sequence_generator.sv =====
// Top level: base-2 Niederreiter point generator, controller plus datapath.
// With the table ready, S_FIN_BUILD starts the query, S_QUERY reads the 63 direction columns one by one and XORs
//   each with the index, S_QDRAIN drains the read and S_DONE loads the result once out_ready frees the output;
//   no new item is taken until S_IDLE. A bad dimension skips the query and S_DONE loads a zero numerator.
// First item after reset also builds the table: trial division, then per dimension 63 column writes plus, per stage,
//   a multiply, a seed and a recurrence. Reset clears the ready flag, out_valid and the sequencer state.
`default_nettype none
module niederreiter_sequence_generator
  import niedgen_pkg::*;
#(
  parameter int DIMENSIONS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [IDX_W-1:0]  in_sample_index,
  input  wire logic [DIM_W-1:0]  in_dimension,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [NUM_W-1:0]       out_point_numerator,
  output logic                   out_bad_dimension
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: accept an item, build the table once, then walk the columns.
  niedgen_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds the item, the build state, the column memory and the result register.
  niedgen_dp #(
    .DIMENSIONS (DIMENSIONS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_sample_index     (in_sample_index),
    .in_dimension        (in_dimension),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_point_numerator (out_point_numerator),
    .out_bad_dimension   (out_bad_dimension)
  );

endmodule
`default_nettype wire

// ===== src/niedgen_ctrl.sv =====
// Sequencer for table build and column-serial query.
`default_nettype none
module niedgen_ctrl
  import niedgen_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_IRR_INIT;
          if (sts.table_ready) begin
            // Bad flag is only valid after capture; decide in next state.
            state_nxt = S_FIN_BUILD;
          end
        end
      end
      S_IRR_INIT: begin
        cmd.irr_init = 1'b1;
        state_nxt    = S_IRR_STEP;
      end
      S_IRR_STEP: begin
        if (sts.irr_done) begin
          cmd.build_start = 1'b1;
          state_nxt       = S_DIM_INIT;
        end else begin
          cmd.irr_step = 1'b1;
        end
      end
      S_DIM_INIT: begin
        cmd.dim_init = 1'b1;
        state_nxt    = S_COL;
      end
      S_COL: begin
        if (sts.u_is_e) begin
          cmd.mul_init = 1'b1;
          state_nxt    = S_MUL;
        end else begin
          cmd.col_write = 1'b1;
          if (sts.col_last) begin
            if (sts.dim_last) begin
              state_nxt = S_FIN_BUILD;
            end else begin
              cmd.dim_next = 1'b1;
              state_nxt    = S_DIM_INIT;
            end
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_REC;
      end
      S_REC: begin
        if (sts.rec_done) state_nxt = S_COL;
        else              cmd.rec_step = 1'b1;
      end
      S_FIN_BUILD: begin
        cmd.set_ready = 1'b1;
        if (sts.dim_bad) begin
          state_nxt = S_DONE;
        end else begin
          cmd.q_start = 1'b1;
          state_nxt   = S_QUERY;
        end
      end
      S_QUERY: begin
        cmd.q_issue = 1'b1;
        if (sts.q_last) state_nxt = S_QDRAIN;
      end
      S_QDRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/niedgen_dp.sv =====
// Datapath: polynomial search, recurrence, column memory and query XOR.
`default_nettype none
module niedgen_dp
  import niedgen_pkg::*;
#(
  parameter int DIMENSIONS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_sts_t                sts,
  input  wire logic [IDX_W-1:0]  in_sample_index,
  input  wire logic [DIM_W-1:0]  in_dimension,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [NUM_W-1:0]       out_point_numerator,
  output logic                   out_bad_dimension
);

  localparam int DW        = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int NW        = $clog2(DIMENSIONS + 1);
  localparam int TAB_DEPTH = IDX_W * DIMENSIONS;
  localparam int AW        = $clog2(TAB_DEPTH);

  function automatic logic [3:0] poly_deg(input logic [POLY_W-1:0] a);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k < POLY_W; k++) begin
      if (a[k]) d = 4'(k);
    end
    return d;
  endfunction

  function automatic logic [AW-1:0] tab_addr(input logic [DW-1:0] d, input logic [5:0] j);
    logic [DW+6:0] s;
    s = {1'b0, d, 6'd0} - (DW+7)'(d) + (DW+7)'(j);
    return s[AW-1:0];
  endfunction

  // query capture
  logic [IDX_W-1:0] idx_q_r;
  logic [DW-1:0]    dim_r;
  logic             bad_r;
  logic             table_ready_r;

  // irreducible search
  logic [POLY_W-1:0] irr_r [DIMENSIONS];
  logic [NW-1:0]     n_r;
  logic [DW-1:0]     sel_r;
  logic [POLY_W-1:0] cand_r, a_r;

  // per-dimension build
  logic [POLY_W-1:0] poly_r;
  logic [3:0]        e_r, u_r, t_r;
  logic [6:0]        m_r, m1_r, i_r;
  logic [5:0]        j_r;
  logic [REC_W-1:0]  prod_r, mac_r, rec_r;

  // column memory and query
  logic [IDX_W-1:0] tab_mem [TAB_DEPTH];
  logic [IDX_W-1:0] rd_data_r;
  logic             rd_v_r;
  logic [5:0]       rd_j_r, qj_r;
  logic [IDX_W-1:0] qacc_r;

  logic                 out_valid_r, out_bad_r;
  logic [NUM_W-1:0]     out_num_r;

  // combinational helpers
  logic [POLY_W-1:0] irr_b, irr_sh;
  logic [3:0]        da, db, pdeg;
  logic [REC_W-1:0]  mac_nxt, win, pmask, seed_vec, col_vec;
  logic              v_bit;
  logic [6:0]        vlen;
  logic              last_div;

  always_comb begin
    irr_b    = irr_r[sel_r];
    da       = poly_deg(a_r);
    db       = poly_deg(irr_b);
    irr_sh   = irr_b << (da - db);
    last_div = ((NW'(sel_r) + NW'(1)) == n_r);
    pdeg     = poly_deg(irr_b);
    mac_nxt  = {mac_r[REC_W-2:0], 1'b0} ^ (poly_r[t_r] ? prod_r : '0);
    win      = rec_r >> (i_r - m_r);
    pmask    = prod_r & ~(REC_W'(1) << m_r);
    v_bit    = ^(pmask & win);
    vlen     = 7'd62 + 7'(e_r);
    col_vec  = rec_r >> u_r;
    for (int k = 0; k < REC_W; k++) begin
      seed_vec[k] = (7'(k) < m_r) ? (7'(k) >= m1_r) : rec_r[k];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
      rd_v_r        <= 1'b0;
    end else begin
      if (cmd.set_ready) table_ready_r <= 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      rd_v_r <= cmd.q_issue;
    end
  end

  // capture item, search irreducibles
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_q_r <= in_sample_index;
      dim_r   <= in_dimension[DW-1:0];
      bad_r   <= ({1'b0, in_dimension} >= 9'(DIMENSIONS));
    end
    if (cmd.irr_init) begin
      irr_r[0] <= FIRST_POLY;
      n_r      <= NW'(1);
      cand_r   <= FIRST_POLY + 16'd1;
      a_r      <= FIRST_POLY + 16'd1;
      sel_r    <= '0;
    end else if (cmd.irr_step) begin
      if (a_r == '0) begin
        cand_r <= cand_r + 16'd1;
        a_r    <= cand_r + 16'd1;
        sel_r  <= '0;
      end else if (da < db) begin
        if (last_div) begin
          irr_r[n_r[DW-1:0]] <= cand_r;
          n_r    <= n_r + NW'(1);
          cand_r <= cand_r + 16'd1;
          a_r    <= cand_r + 16'd1;
          sel_r  <= '0;
        end else begin
          sel_r <= sel_r + DW'(1);
          a_r   <= cand_r;
        end
      end else begin
        a_r <= a_r ^ irr_sh;
      end
    end else if (cmd.build_start) begin
      sel_r <= '0;
    end else if (cmd.dim_next) begin
      sel_r <= sel_r + DW'(1);
    end
  end

  // build one dimension
  always_ff @(posedge clk) begin
    if (cmd.dim_init) begin
      poly_r <= irr_b;
      e_r    <= (pdeg == 4'd0) ? 4'd1 : pdeg;
      u_r    <= (pdeg == 4'd0) ? 4'd1 : pdeg;
      prod_r <= REC_W'(1);
      m_r    <= '0;
      j_r    <= 6'd62;
    end
    if (cmd.mul_init) begin
      m1_r  <= m_r;
      mac_r <= '0;
      t_r   <= e_r;
    end
    if (cmd.mul_step) begin
      mac_r <= mac_nxt;
      if (t_r == 4'd0) begin
        prod_r <= mac_nxt;
        m_r    <= m_r + 7'(e_r);
      end else begin
        t_r <= t_r - 4'd1;
      end
    end
    if (cmd.seed) begin
      rec_r <= seed_vec;
      i_r   <= m_r;
      u_r   <= '0;
    end
    if (cmd.rec_step) begin
      rec_r[i_r] <= v_bit;
      i_r        <= i_r + 7'd1;
    end
    if (cmd.col_write) begin
      u_r <= u_r + 4'd1;
      j_r <= j_r - 6'd1;
    end
  end

  // column memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.col_write) tab_mem[tab_addr(sel_r, j_r)] <= col_vec[IDX_W-1:0];
    if (cmd.q_issue) rd_data_r <= tab_mem[tab_addr(dim_r, qj_r)];
  end

  // query accumulate and output register
  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      qj_r   <= '0;
      qacc_r <= '0;
    end else begin
      if (cmd.q_issue) qj_r <= qj_r + 6'd1;
      if (rd_v_r) qacc_r[rd_j_r] <= ^(rd_data_r & idx_q_r);
    end
    rd_j_r <= qj_r;
    if (cmd.out_load) begin
      out_bad_r <= bad_r;
      out_num_r <= bad_r ? '0 : ({1'b0, qacc_r} + NUM_W'(1));
    end
  end

  always_comb begin
    sts.table_ready = table_ready_r;
    sts.dim_bad     = bad_r;
    sts.irr_done    = (n_r == NW'(DIMENSIONS));
    sts.u_is_e      = (u_r == e_r);
    sts.mul_last    = (t_r == 4'd0);
    sts.rec_done    = (i_r >= vlen);
    sts.col_last    = (j_r == 6'd0);
    sts.dim_last    = (sel_r == DW'(DIMENSIONS - 1));
    sts.q_last      = (qj_r == 6'd62);
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid           = out_valid_r;
  assign out_point_numerator = out_num_r;
  assign out_bad_dimension   = out_bad_r;

endmodule
`default_nettype wire
